FILE: hw/rtl/xtm_pkg.sv
// Shared constants, codes and beat types of the tag matching stack.
`default_nettype none

package xtm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int NAME_BYTES  = 32;

  localparam int SPW  = $clog2(STACK_DEPTH + 1);
  localparam int TOPW = $clog2(STACK_DEPTH);
  localparam int BCW  = $clog2(NAME_BYTES + 1);
  localparam int POSW = $clog2(NAME_BYTES);
  localparam int EIW  = BCW + 1;
  localparam int NSD  = STACK_DEPTH * NAME_BYTES;
  localparam int NSA  = $clog2(NSD);

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef enum logic [1:0] {
    ACT_PUSH_START = 2'd0,
    ACT_POP        = 2'd1,
    ACT_PUSH_END   = 2'd2
  } action_t;

  typedef struct packed {
    logic       cmd;
    logic       tag_kind;
    logic       first_byte;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    action_t    action;
    logic [6:0] depth;
    logic [5:0] name_length;
    logic       name_truncated;
    logic       stack_overflow;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xtm_if.sv
// Valid/ready channel interfaces for input and result beats.
`default_nettype none

interface xtm_in_if;
  logic               valid;
  logic               ready;
  xtm_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xtm_out_if;
  logic               valid;
  logic               ready;
  xtm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/xtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module xtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/xtm_ctrl.sv
// Stack control: name write-ahead, byte compare against the top entry, push and pop.
`default_nettype none

module xtm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  xtm_pkg::in_item_t item,
  output xtm_pkg::result_t  res
);
  import xtm_pkg::*;

  logic [SPW-1:0]  sp_r, sp_nxt;
  logic [BCW-1:0]  bc_r, bc_nxt;
  logic            coll_r, coll_nxt;
  logic            dif_r, dif_nxt;
  logic            kind_r, kind_nxt;
  logic            ovl_r, ovl_nxt;
  logic            fwd_r, fwd_nxt;
  logic [EIW-1:0]  fwd_info_r;

  logic            cur_coll, cur_kind, cur_dif, cur_ovl;
  logic [BCW-1:0]  cur_bc;
  logic            is_term, do_match, do_push, dropped;
  logic [7:0]      ref_byte;
  logic [EIW-1:0]  top_info;
  logic [BCW-1:0]  top_len;
  logic            top_kind;
  logic [TOPW-1:0] top_nxt;
  logic [POSW-1:0] pos_nxt;
  logic [SPW+6:0]  depth_wide;
  logic [BCW+5:0]  len_wide;

  logic            ns_we;
  logic [NSA-1:0]  ns_waddr, nsa_raddr, ns0_raddr;
  logic [7:0]      nsa_rdata, ns0_rdata;
  logic            ei_we;
  logic [TOPW-1:0] ei_waddr;
  logic [EIW-1:0]  ei_wdata, ei_rdata;

  // entry info written in the same cycle as the prefetch read of its address
  assign top_info = fwd_r ? fwd_info_r : ei_rdata;
  assign top_len  = top_info[BCW-1:0];
  assign top_kind = top_info[EIW-1];
  assign is_term  = (item.char_byte == CH_SPACE) || (item.char_byte == CH_GT);
  // first byte restarts at position 0, served by the second copy
  assign ref_byte = item.first_byte ? ns0_rdata : nsa_rdata;

  always_comb begin
    sp_nxt   = sp_r;
    bc_nxt   = bc_r;
    coll_nxt = coll_r;
    dif_nxt  = dif_r;
    kind_nxt = kind_r;
    ovl_nxt  = ovl_r;
    cur_coll = item.first_byte | coll_r;
    cur_kind = item.first_byte ? item.tag_kind : kind_r;
    cur_bc   = item.first_byte ? '0 : bc_r;
    cur_dif  = item.first_byte ? 1'b0 : dif_r;
    cur_ovl  = item.first_byte ? 1'b0 : ovl_r;
    do_match = 1'b0;
    do_push  = 1'b0;
    dropped  = 1'b0;
    ns_we    = 1'b0;
    ei_we    = 1'b0;
    res      = '0;
    ns_waddr = NSA'(NSA'(sp_r) * NSA'(NAME_BYTES) + NSA'(cur_bc));
    ei_waddr = sp_r[TOPW-1:0];
    ei_wdata = {cur_kind, cur_bc};
    if (acc) begin
      if (item.cmd == CMD_CLEAR) begin
        sp_nxt   = '0;
        bc_nxt   = '0;
        coll_nxt = 1'b0;
        dif_nxt  = 1'b0;
        kind_nxt = KIND_START;
        ovl_nxt  = 1'b0;
      end else if (cur_coll) begin
        coll_nxt = 1'b1;
        kind_nxt = cur_kind;
        bc_nxt   = cur_bc;
        dif_nxt  = cur_dif;
        ovl_nxt  = cur_ovl;
        if (!is_term) begin
          if (cur_bc >= BCW'(NAME_BYTES)) begin
            ovl_nxt = 1'b1;
          end else begin
            ns_we   = sp_r < SPW'(STACK_DEPTH);
            dif_nxt = cur_dif | ((sp_r != '0) && (cur_bc < top_len) &&
                                 (ref_byte != item.char_byte));
            bc_nxt  = BCW'(cur_bc + 1'b1);
          end
        end else begin
          do_push = 1'b1;
          res.item.action = ACT_PUSH_START;
          if (cur_kind == KIND_END) begin
            do_match = (sp_r != '0) && (top_kind == KIND_START) &&
                       (top_len == cur_bc) && !cur_dif;
            if (do_match) begin
              do_push = 1'b0;
              res.item.action = ACT_POP;
              sp_nxt = SPW'(sp_r - 1'b1);
            end else begin
              res.item.action = ACT_PUSH_END;
            end
          end
          dropped = do_push && (sp_r >= SPW'(STACK_DEPTH));
          if (do_push && !dropped) begin
            ei_we  = 1'b1;
            sp_nxt = SPW'(sp_r + 1'b1);
          end
          res.valid = 1'b1;
          res.item.name_truncated = cur_ovl;
          res.item.stack_overflow = dropped;
          coll_nxt = 1'b0;
          bc_nxt   = '0;
          dif_nxt  = 1'b0;
          ovl_nxt  = 1'b0;
        end
      end
    end
    depth_wide = {7'd0, sp_nxt};
    len_wide   = {6'd0, cur_bc};
    res.item.depth       = depth_wide[6:0];
    res.item.name_length = len_wide[5:0];
  end

  // prefetch the top entry for the state after this beat
  always_comb begin
    top_nxt   = (sp_nxt == '0) ? '0 : TOPW'(sp_nxt - 1'b1);
    pos_nxt   = (bc_nxt < BCW'(NAME_BYTES)) ? bc_nxt[POSW-1:0] : '0;
    ns0_raddr = NSA'(NSA'(top_nxt) * NSA'(NAME_BYTES));
    nsa_raddr = NSA'(ns0_raddr + NSA'(pos_nxt));
    fwd_nxt   = ei_we && (ei_waddr == top_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      bc_r   <= '0;
      coll_r <= 1'b0;
      dif_r  <= 1'b0;
      kind_r <= KIND_START;
      ovl_r  <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      sp_r   <= sp_nxt;
      bc_r   <= bc_nxt;
      coll_r <= coll_nxt;
      dif_r  <= dif_nxt;
      kind_r <= kind_nxt;
      ovl_r  <= ovl_nxt;
      fwd_r  <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_info_r <= ei_wdata;
  end

  xtm_ram #(.WIDTH(8), .DEPTH(NSD)) u_name_a (
    .clk     (clk),
    .wr_en   (ns_we),
    .wr_addr (ns_waddr),
    .wr_data (item.char_byte),
    .rd_addr (nsa_raddr),
    .rd_data (nsa_rdata)
  );

  // copy of the name store for the byte-0 read port
  xtm_ram #(.WIDTH(8), .DEPTH(NSD)) u_name_0 (
    .clk     (clk),
    .wr_en   (ns_we),
    .wr_addr (ns_waddr),
    .wr_data (item.char_byte),
    .rd_addr (ns0_raddr),
    .rd_data (ns0_rdata)
  );

  xtm_ram #(.WIDTH(EIW), .DEPTH(STACK_DEPTH)) u_entry (
    .clk     (clk),
    .wr_en   (ei_we),
    .wr_addr (ei_waddr),
    .wr_data (ei_wdata),
    .rd_addr (top_nxt),
    .rd_data (ei_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/xtm_obuf.sv
// Two-entry result buffer between the stack control and the result channel.
`default_nettype none

module xtm_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  xtm_pkg::result_t res,
  output logic             ready,
  xtm_out_if.source        out_bus
);
  import xtm_pkg::*;

  out_item_t  slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop          = out_bus.valid && out_bus.ready;
  assign out_bus.valid = cnt_r != 2'd0;
  assign out_bus.data  = slot_r[rp_r];
  assign ready         = cnt_r != 2'd2;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res.valid && !pop) begin
      cnt_nxt = 2'(cnt_r + 1'b1);
    end else if (!res.valid && pop) begin
      cnt_nxt = 2'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res.valid) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      slot_r[wp_r] <= res.item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/xml_tag_match_stack.sv
// Top level of the balanced tag matching stack.
`default_nettype none

// Takes one tag-name byte per cycle and gives one result beat per finished name,
// placed in a two-entry result buffer in the cycle the terminator beat is taken.
// Bytes are written ahead into the free slot above the stack top while the top
// entry's stored byte at the same position is prefetched from the name store
// (kept as two copies, so position 0 is always ready for a new name's first
// byte), and the top entry's kind and length come from a small entry memory
// with write forwarding. Sustained rate is one beat per cycle, including
// back-to-back pushes and pops; input ready drops only while both result
// buffer entries are held by the downstream side. A clear beat empties the
// stack at once; the memories need no clearing pass after reset.
module xml_tag_match_stack (
  input  logic      clk,
  input  logic      rst_n,
  xtm_in_if.sink    in_bus,
  xtm_out_if.source out_bus
);
  import xtm_pkg::*;

  logic    buf_ready;
  logic    acc;
  result_t res;

  assign in_bus.ready = buf_ready;
  assign acc          = in_bus.valid && in_bus.ready;

  xtm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .item  (in_bus.data),
    .res   (res)
  );

  xtm_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .ready   (buf_ready),
    .out_bus (out_bus)
  );

`ifndef SYNTHESIS
  a_pop_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && (out_bus.data.action == ACT_POP) |-> !out_bus.data.stack_overflow)
    else $error("pop reported with overflow");

  a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.data.name_truncated
      |-> (out_bus.data.name_length == 6'(NAME_BYTES)))
    else $error("truncated name without full stored length");

  a_stall_means_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid)
    else $error("input stalled with empty result buffer");

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_bus.data.cmd == CMD_CLEAR) |-> !res.valid)
    else $error("clear beat produced a result");
`endif

endmodule

`default_nettype wire

FILE: test/xml_tag_match_stack_test.sv
// Self-checking testbench for the tag matching stack: driver, tracker and result checker.
module xml_tag_match_stack_test;
  import xtm_pkg::*;

  localparam int ITEMS       = 1700;
  localparam int STALL_LIMIT = 4000;
  localparam int NAME_MAX    = 40;

  typedef logic [7:0] name_t [NAME_MAX];

  typedef struct {
    in_item_t beat;
    int       gap;
    bit       drain;
  } tag_beat_t;

  logic clk;
  logic rst_n;

  xtm_in_if  in_ch ();
  xtm_out_if out_ch ();

  xml_tag_match_stack dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  tag_beat_t tag_beats[$];
  out_item_t result_q[$];
  int        total_beats;
  int        counted_items;
  bit        drain_next;
  int        beats_taken   = 0;
  int        results_due   = 0;
  int        results_seen  = 0;
  int        err_count     = 0;
  logic      rx_hold       = 1'b0;

  // Tracker state: a copy of the stack as the block should hold it.
  logic [7:0] name_bytes [NSD];
  logic       entry_kind [STACK_DEPTH];
  int         entry_len  [STACK_DEPTH];
  int         depth_ptr;
  int         name_cnt;
  bit         in_name;
  bit         name_differs;
  logic       name_kind;
  bit         name_long;

  function automatic void reset_tracker();
    foreach (name_bytes[i]) name_bytes[i] = '0;
    foreach (entry_kind[i]) begin
      entry_kind[i] = KIND_START;
      entry_len[i]  = 0;
    end
    depth_ptr    = 0;
    name_cnt     = 0;
    in_name      = 0;
    name_differs = 0;
    name_kind    = KIND_START;
    name_long    = 0;
  endfunction

  function automatic bit push_tag(logic kind, int len);
    if (depth_ptr >= STACK_DEPTH) return 1'b1;
    entry_kind[depth_ptr] = kind;
    entry_len[depth_ptr]  = len;
    depth_ptr++;
    return 1'b0;
  endfunction

  function automatic void track_tag_byte(input in_item_t b, output bit has_result,
                                         output out_item_t r);
    int      len;
    bit      dropped;
    bit      match;
    action_t act;
    has_result = 0;
    r          = '0;
    dropped    = 0;
    if (b.cmd == CMD_CLEAR) begin
      depth_ptr    = 0;
      name_cnt     = 0;
      in_name      = 0;
      name_differs = 0;
      name_kind    = KIND_START;
      name_long    = 0;
      return;
    end
    if (b.first_byte) begin
      in_name      = 1;
      name_kind    = b.tag_kind;
      name_cnt     = 0;
      name_differs = 0;
      name_long    = 0;
    end
    if (!in_name) return;
    if (b.char_byte != CH_SPACE && b.char_byte != CH_GT) begin
      if (name_cnt >= NAME_BYTES) begin
        name_long = 1;
      end else begin
        // written ahead into the free slot, compared against the top entry
        if (depth_ptr < STACK_DEPTH) name_bytes[depth_ptr * NAME_BYTES + name_cnt] = b.char_byte;
        if (depth_ptr > 0 && name_cnt < entry_len[depth_ptr - 1] &&
            name_bytes[(depth_ptr - 1) * NAME_BYTES + name_cnt] != b.char_byte)
          name_differs = 1;
        name_cnt++;
      end
      return;
    end
    len = name_cnt;
    if (name_kind == KIND_START) begin
      act     = ACT_PUSH_START;
      dropped = push_tag(KIND_START, len);
    end else begin
      match = depth_ptr > 0 && entry_kind[depth_ptr - 1] == KIND_START &&
              entry_len[depth_ptr - 1] == len && !name_differs;
      if (match) begin
        act = ACT_POP;
        depth_ptr--;
      end else begin
        act     = ACT_PUSH_END;
        dropped = push_tag(KIND_END, len);
      end
    end
    r.action         = act;
    r.depth          = 7'(depth_ptr);
    r.name_length    = 6'(len);
    r.name_truncated = name_long;
    r.stack_overflow = dropped;
    has_result   = 1;
    in_name      = 0;
    name_cnt     = 0;
    name_differs = 0;
    name_long    = 0;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_name_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return 8'h61 + 8'($urandom_range(0, 3));
    do c = 8'($urandom_range(0, 255)); while (c == CH_SPACE || c == CH_GT);
    return c;
  endfunction

  function automatic logic [7:0] rand_term();
    return ($urandom_range(0, 1) == 1) ? CH_SPACE : CH_GT;
  endfunction

  function automatic logic rand_bit();
    return ($urandom_range(0, 1) == 1);
  endfunction

  task automatic add_beat(input logic cmd, input logic kind, input logic first,
                          input logic [7:0] ch, input bit counts);
    tag_beat_t t;
    t.beat.cmd        = cmd;
    t.beat.tag_kind   = kind;
    t.beat.first_byte = first;
    t.beat.char_byte  = ch;
    // no idling at all in every fourth stretch of 120 beats
    t.gap   = ((tag_beats.size() / 120) % 4 == 0) ? 0 : idle_len();
    t.drain = drain_next;
    drain_next = 0;
    tag_beats.push_back(t);
    if (counts) counted_items++;
  endtask

  // kind is only sampled on the first beat, so the others carry noise there
  task automatic add_tag(input logic kind, input name_t nm, input int len);
    logic [7:0] term;
    term = rand_term();
    if (len == 0) begin
      add_beat(CMD_BYTE, kind, 1'b1, term, 1);
    end else begin
      add_beat(CMD_BYTE, kind, 1'b1, nm[0], 1);
      for (int i = 1; i < len; i++) add_beat(CMD_BYTE, rand_bit(), 1'b0, nm[i], 1);
      add_beat(CMD_BYTE, rand_bit(), 1'b0, term, 1);
    end
    // attribute bytes after a space fall outside any name
    if (term == CH_SPACE)
      repeat ($urandom_range(0, 4))
        add_beat(CMD_BYTE, rand_bit(), 1'b0, 8'($urandom_range(0, 255)), 1);
  endtask

  task automatic gen_name(output name_t nm, output int len);
    int p;
    p = $urandom_range(0, 99);
    if (p < 10) len = 0;
    else if (p < 85) len = $urandom_range(1, 6);
    else len = $urandom_range(NAME_BYTES - 4, NAME_BYTES + 4);
    foreach (nm[i]) nm[i] = rand_name_byte();
  endtask

  task automatic emit_partial();
    name_t nm;
    int    len;
    gen_name(nm, len);
    add_beat(CMD_BYTE, rand_bit(), 1'b1, nm[0], 1);
    for (int i = 1; i < $urandom_range(1, 4); i++) add_beat(CMD_BYTE, rand_bit(), 1'b0, nm[i], 1);
  endtask

  // Nested start/end pairs, mostly matching, some broken, some left open.
  task automatic emit_document();
    name_t      open_nm [16];
    int         open_len [16];
    int         open_cnt;
    name_t      nm;
    int         len;
    int         pos;
    logic [7:0] old;
    open_cnt = 0;
    repeat ($urandom_range(4, 30)) begin
      if (open_cnt < 16 && (open_cnt == 0 || rand_bit())) begin
        if ($urandom_range(0, 9) == 0) emit_partial();
        gen_name(nm, len);
        add_tag(KIND_START, nm, len);
        open_nm[open_cnt]  = nm;
        open_len[open_cnt] = len;
        open_cnt++;
      end else begin
        open_cnt--;
        nm  = open_nm[open_cnt];
        len = open_len[open_cnt];
        case ($urandom_range(0, 9))
          0: if (len > 0) begin
            pos = $urandom_range(0, len - 1);
            old = nm[pos];
            do nm[pos] = rand_name_byte(); while (nm[pos] == old);
          end
          1: if (len > 0 && rand_bit()) len--;
             else len++;
          // bytes past the stored part do not take part in the match
          2: if (len > NAME_BYTES) nm[$urandom_range(NAME_BYTES, len - 1)] = rand_name_byte();
          default: ;
        endcase
        add_tag(KIND_END, nm, len);
      end
    end
    if ($urandom_range(0, 9) < 7)
      while (open_cnt > 0) begin
        open_cnt--;
        add_tag(KIND_END, open_nm[open_cnt], open_len[open_cnt]);
      end
  endtask

  task automatic emit_overflow();
    name_t nm;
    if (rand_bit()) add_beat(CMD_CLEAR, rand_bit(), rand_bit(), 8'($urandom_range(0, 255)), 1);
    repeat ($urandom_range(STACK_DEPTH, STACK_DEPTH + 6))
      add_beat(CMD_BYTE, KIND_START, 1'b1, rand_term(), 1);
    foreach (nm[i]) nm[i] = rand_name_byte();
    add_tag(KIND_END, nm, $urandom_range(1, 3));
    repeat ($urandom_range(0, 4)) add_beat(CMD_BYTE, KIND_END, 1'b1, rand_term(), 1);
    if (rand_bit()) add_beat(CMD_CLEAR, rand_bit(), rand_bit(), 8'($urandom_range(0, 255)), 1);
  endtask

  task automatic emit_noise();
    logic [7:0] c;
    int         p;
    repeat ($urandom_range(5, 20)) begin
      p = $urandom_range(0, 3);
      c = (p == 0) ? CH_SPACE : (p == 1) ? CH_GT : 8'($urandom_range(0, 255));
      add_beat(($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_BYTE, rand_bit(), rand_bit(), c, 1);
    end
  endtask

  task automatic build_stimulus();
    name_t nm;
    int    next_drain;
    int    p;
    foreach (nm[i]) nm[i] = 8'h00;
    // byte outside a name
    add_beat(CMD_BYTE, KIND_END, 1'b0, 8'h51, 1);
    // empty start, then empty end that matches it
    add_beat(CMD_BYTE, KIND_START, 1'b1, CH_GT, 1);
    add_beat(CMD_BYTE, KIND_END, 1'b1, CH_SPACE, 1);
    nm[0] = 8'h61;
    nm[1] = 8'h62;
    add_beat(CMD_BYTE, KIND_START, 1'b1, nm[0], 1);
    add_beat(CMD_BYTE, KIND_END, 1'b0, nm[1], 1);
    add_beat(CMD_BYTE, KIND_END, 1'b0, CH_GT, 1);
    add_beat(CMD_BYTE, KIND_END, 1'b1, nm[0], 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, nm[1], 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, CH_SPACE, 1);
    // end tag on an empty stack
    add_beat(CMD_BYTE, KIND_END, 1'b1, 8'h63, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, CH_SPACE, 1);
    // extreme byte values in a name
    add_beat(CMD_BYTE, KIND_START, 1'b1, 8'h00, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, 8'hFF, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, CH_GT, 1);
    // new name starts while one is in progress, then closes the one above
    add_beat(CMD_BYTE, KIND_START, 1'b1, 8'h78, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, 8'h79, 1);
    add_beat(CMD_BYTE, KIND_END, 1'b1, 8'h00, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, 8'hFF, 1);
    add_beat(CMD_BYTE, KIND_START, 1'b0, CH_GT, 1);
    add_beat(CMD_CLEAR, KIND_END, 1'b1, 8'hFF, 1);

    drain_next = 1;
    next_drain = counted_items + 400;
    while (counted_items < ITEMS) begin
      if (counted_items >= next_drain) begin
        drain_next = 1;
        next_drain += 400;
      end
      p = $urandom_range(0, 99);
      if (p < 60) emit_document();
      else if (p < 64) emit_overflow();
      else if (p < 80) emit_noise();
      else if (p < 88) add_beat(CMD_CLEAR, rand_bit(), rand_bit(), 8'($urandom_range(0, 255)), 1);
      else begin
        emit_partial();
        if (rand_bit()) add_beat(CMD_CLEAR, rand_bit(), rand_bit(), rand_term(), 1);
      end
    end
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk) begin : feed
    logic      nxt_valid;
    in_item_t  nxt_beat;
    out_item_t r;
    bit        has;
    tag_beat_t t;
    int        tx_wait;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      tx_wait = 0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_beat  = in_ch.data;
      has       = 0;
      if (in_ch.valid && in_ch.ready) begin
        track_tag_byte(in_ch.data, has, r);
        if (has) result_q.push_back(r);
        beats_taken <= beats_taken + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && tag_beats.size() != 0) begin
        if (tx_wait < tag_beats[0].gap) begin
          tx_wait++;
        end else if (!tag_beats[0].drain || results_due + int'(has) == results_seen) begin
          t = tag_beats.pop_front();
          nxt_beat  = t.beat;
          nxt_valid = 1'b1;
          tx_wait   = 0;
        end
      end
      if (has) results_due <= results_due + 1;
      in_ch.valid <= nxt_valid;
      in_ch.data  <= nxt_beat;
    end
  end

  always @(posedge clk) begin : drain_results
    out_item_t want;
    int        rx_wait;
    int        rx_beats;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait  = 0;
      rx_beats = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_seen == results_due) begin
          err_count++;
          $error("result beat with no expectation waiting: %p", out_ch.data);
        end else begin
          want = result_q.pop_front();
          check_field("action", 8'(want.action), 8'(out_ch.data.action));
          check_field("depth", 8'(want.depth), 8'(out_ch.data.depth));
          check_field("name_length", 8'(want.name_length), 8'(out_ch.data.name_length));
          check_field("name_truncated", 8'(want.name_truncated),
                      8'(out_ch.data.name_truncated));
          check_field("stack_overflow", 8'(want.stack_overflow),
                      8'(out_ch.data.stack_overflow));
          results_seen <= results_seen + 1;
        end
        rx_beats++;
        rx_wait = ((rx_beats / 100) % 3 == 0) ? 0 : idle_len();
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_hold;
      end
    end
  end

  // Long receiver hold-off so the result buffer fills and input ready drops.
  initial begin : rx_pressure
    while (rst_n !== 1'b1) @(posedge clk);
    repeat (400) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin : watchdog
    int idle;
    if (!rst_n) begin
      idle = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : run
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    counted_items = 0;
    drain_next    = 0;
    reset_tracker();
    build_stimulus();
    total_beats = tag_beats.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (beats_taken != total_beats || results_due != results_seen) @(posedge clk);
    repeat (20) @(posedge clk);
    if (result_q.size() != 0) begin
      err_count++;
      $error("%0d expected results never arrived", result_q.size());
    end
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/xtm_pkg.sv
hw/rtl/xtm_if.sv
hw/rtl/xtm_ram.sv
hw/rtl/xtm_ctrl.sv
hw/rtl/xtm_obuf.sv
hw/rtl/xml_tag_match_stack.sv
test/xml_tag_match_stack_test.sv
